/* hdl/tld_pkg.sv */
// ----------------------------------------------------------------------------
// tld_pkg: shared types and constants for the terminal line discipline
// Sizes, command and result codes, character codes and register layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tld_pkg;
    localparam int LINE_SIZE = 64;
    localparam int RING_SIZE = 256;
    localparam int LINE_AW   = $clog2(LINE_SIZE);
    localparam int RING_AW   = $clog2(RING_SIZE);
    localparam int CNT_W     = $clog2(RING_SIZE + 1);

    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [2:0] K_DONE  = 3'd0;
    localparam logic [2:0] K_ECHO  = 3'd1;
    localparam logic [2:0] K_READ  = 3'd2;
    localparam logic [2:0] K_EOF   = 3'd3;
    localparam logic [2:0] K_NONE  = 3'd4;
    localparam logic [2:0] K_ERASE = 3'd5;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_INTR  = 3'd1;
    localparam logic [2:0] REG_EOF   = 3'd2;
    localparam logic [2:0] REG_SUSP  = 3'd3;
    localparam logic [2:0] REG_ERASE = 3'd4;
    localparam logic [2:0] REG_KILL  = 3'd5;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] intr;
        logic [7:0] eofc;
        logic [7:0] susp;
        logic [7:0] erase;
        logic [7:0] kill;
    } t_cfg;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic       is_intr;
        logic       is_eof;
        logic       is_susp;
        logic       is_erase;
        logic       is_kill;
        logic       is_nl;
    } t_work;

    function automatic logic can_read(input logic eof_f, input logic rdy_f,
                                      input logic canon, input logic [CNT_W-1:0] cnt);
        can_read = (eof_f && cnt == '0) || (!canon && rdy_f) || (cnt != '0);
    endfunction
endpackage
`default_nettype wire

/* hdl/tld_if.sv */
// ----------------------------------------------------------------------------
// tld_in_if / tld_out_if: command and result channels
// Valid/ready channels carrying one command word or one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tld_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] key;
    modport source (output valid, command, key, input ready);
    modport sink   (input valid, command, key, output ready);
endinterface

interface tld_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
    logic       readable;
    modport source (output valid, kind, value, last, readable, input ready);
    modport sink   (input valid, kind, value, last, readable, output ready);
endinterface
`default_nettype wire

/* hdl/terminal_line_discipline.sv */
// ----------------------------------------------------------------------------
// terminal_line_discipline: terminal input line discipline
// Canonical/raw key handling with line buffer, input ring and echo results.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command word (key, read, flush); o_res returns its result
//   words, the final one flagged by last. Every result word carries readable,
//   the state seen by a reader after the command.
//   Registers sit on the APB port at byte address 4*index; writes complete
//   in the access cycle, pready is always high, and reads return the value.
//   Sequence: a command moves from the queue into the back end, executes
//   (a read that returns data first fetches its byte from the ring) and
//   then emits its result words. A line commit (newline or end of file on a
//   non-empty line) walks the line buffer, reading then writing each byte
//   into the ring, and then appends the newline.
//   A two-word queue lets the front accept commands while the back works.
//   A stalled receiver holds the result register; the back waits and the
//   queue fills, then i_cmd.ready drops.
//   Reset empties line, ring, flags and queue and restores default registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module terminal_line_discipline (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [4:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready,
    tld_in_if.sink     i_cmd,
    tld_out_if.source  o_res
);
    import tld_pkg::*;

    t_cfg       r_cfg;
    t_work      w_work;
    logic       w_work_valid, w_work_ready;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= 4'd15;
            r_cfg.intr  <= 8'd3;
            r_cfg.eofc  <= 8'd4;
            r_cfg.susp  <= 8'd26;
            r_cfg.erase <= 8'd127;
            r_cfg.kill  <= 8'd21;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_MODE:  r_cfg.mode  <= pwdata[3:0];
                REG_INTR:  r_cfg.intr  <= pwdata[7:0];
                REG_EOF:   r_cfg.eofc  <= pwdata[7:0];
                REG_SUSP:  r_cfg.susp  <= pwdata[7:0];
                REG_ERASE: r_cfg.erase <= pwdata[7:0];
                REG_KILL:  r_cfg.kill  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            REG_MODE:  prdata = {28'd0, r_cfg.mode};
            REG_INTR:  prdata = {24'd0, r_cfg.intr};
            REG_EOF:   prdata = {24'd0, r_cfg.eofc};
            REG_SUSP:  prdata = {24'd0, r_cfg.susp};
            REG_ERASE: prdata = {24'd0, r_cfg.erase};
            REG_KILL:  prdata = {24'd0, r_cfg.kill};
            default:   prdata = 32'd0;
        endcase
    end

    tld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (i_cmd),
        .o_work_valid (w_work_valid),
        .o_work       (w_work),
        .i_work_ready (w_work_ready)
    );

    tld_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_work_valid (w_work_valid),
        .i_work       (w_work),
        .o_work_ready (w_work_ready),
        .o_res        (o_res)
    );
endmodule
`default_nettype wire

/* hdl/tld_front.sv */
// ----------------------------------------------------------------------------
// tld_front: command intake and classification
// Translates CR, flags special characters and queues two words for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tld_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  tld_pkg::t_cfg  i_cfg,
    tld_in_if.sink         i_cmd,
    output logic           o_work_valid,
    output tld_pkg::t_work o_work,
    input  wire            i_work_ready
);
    import tld_pkg::*;

    t_work      r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    t_work      w_cls;
    logic [7:0] w_ch;
    logic       w_sig, w_push, w_pop;

    // classify the incoming word
    always_comb begin
        w_ch  = (i_cfg.mode[0] && i_cmd.key == CH_CR) ? CH_NL : i_cmd.key;
        w_sig = i_cfg.mode[1];
        w_cls.cmd      = i_cmd.command;
        w_cls.ch       = w_ch;
        w_cls.is_intr  = w_sig && w_ch == i_cfg.intr;
        w_cls.is_eof   = w_sig && w_ch == i_cfg.eofc;
        w_cls.is_susp  = w_sig && w_ch == i_cfg.susp;
        w_cls.is_erase = w_ch == CH_BS || w_ch == i_cfg.erase;
        w_cls.is_kill  = w_ch == i_cfg.kill;
        w_cls.is_nl    = w_ch == CH_NL;
    end

    assign i_cmd.ready  = r_cnt != 2'd2;
    assign w_push       = i_cmd.valid && i_cmd.ready;
    assign o_work_valid = r_cnt != 2'd0;
    assign o_work       = r_q[r_rd];
    assign w_pop        = o_work_valid && i_work_ready;

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= w_cls;
                r_wr      <= ~r_wr;
            end
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

/* hdl/tld_back.sv */
// ----------------------------------------------------------------------------
// tld_back: line editing, input ring and result sequencing
// Holds line and ring memories, walks commits, and emits result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tld_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  tld_pkg::t_cfg  i_cfg,
    input  wire            i_work_valid,
    input  tld_pkg::t_work i_work,
    output logic           o_work_ready,
    tld_out_if.source      o_res
);
    import tld_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_CPRD = 3'd2;
    localparam logic [2:0] S_CPWR = 3'd3;
    localparam logic [2:0] S_CPNL = 3'd4;
    localparam logic [2:0] S_RDWT = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [7:0] line_mem [LINE_SIZE];
    logic [7:0] ring_mem [RING_SIZE];
    logic [7:0] r_line_q, r_ring_q;

    logic [2:0]         r_state, n_state;
    t_work              r_work;
    logic [LINE_AW-1:0] r_len, n_len, r_idx, n_idx, r_nerase, n_nerase;
    logic [RING_AW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_rdy_f, n_rdy_f, r_eof_f, n_eof_f;
    logic [2:0][7:0]    r_echo, n_echo;
    logic [1:0]         r_necho, n_necho, r_eidx, n_eidx;
    logic [2:0]         r_fkind, n_fkind;
    logic [7:0]         r_fvalue, n_fvalue;
    logic               r_ovalid, n_ovalid, r_olast, n_olast, r_oread, n_oread;
    logic [2:0]         r_okind, n_okind;
    logic [7:0]         r_ovalue, n_ovalue;

    logic               w_lwe, w_rwe, w_echo_on, w_canon, w_free;
    logic [7:0]         w_rdata;

    assign w_echo_on    = i_cfg.mode[3];
    assign w_canon      = i_cfg.mode[2];
    assign o_work_ready = r_state == S_IDLE;
    assign w_free       = !r_ovalid || o_res.ready;

    // memories: line written by append, ring written by pushes
    always_ff @(posedge i_clk) begin
        if (w_lwe) line_mem[r_len] <= r_work.ch;
        if (w_rwe) ring_mem[r_tail] <= w_rdata;
        r_line_q <= line_mem[r_idx];
        r_ring_q <= ring_mem[r_head];
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_idx    = r_idx;
        n_nerase = r_nerase;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_rdy_f  = r_rdy_f;
        n_eof_f  = r_eof_f;
        n_echo   = r_echo;
        n_necho  = r_necho;
        n_eidx   = r_eidx;
        n_fkind  = r_fkind;
        n_fvalue = r_fvalue;
        n_ovalid = r_ovalid && !o_res.ready;
        n_okind  = r_okind;
        n_ovalue = r_ovalue;
        n_olast  = r_olast;
        n_oread  = r_oread;
        w_lwe    = 1'b0;
        w_rwe    = 1'b0;
        w_rdata  = r_work.ch;
        unique case (r_state)
            S_IDLE: begin
                n_necho  = 2'd0;
                n_eidx   = 2'd0;
                n_nerase = '0;
                n_idx    = '0;
                n_fkind  = K_DONE;
                n_fvalue = 8'd0;
                if (i_work_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_EMIT;
                priority case (r_work.cmd)
                    CMD_KEY: begin
                        priority if (r_work.is_intr) begin
                            n_echo  = {CH_NL, CH_C, CH_CARET};
                            n_necho = w_echo_on ? 2'd3 : 2'd0;
                            n_len   = '0;
                        end else if (r_work.is_eof) begin
                            if (r_len == '0) begin
                                n_eof_f = 1'b1;
                                n_rdy_f = 1'b1;
                            end else begin
                                n_state = S_CPRD;
                            end
                        end else if (r_work.is_susp) begin
                            n_echo  = {CH_NL, CH_Z, CH_CARET};
                            n_necho = w_echo_on ? 2'd3 : 2'd0;
                        end else if (w_canon) begin
                            priority if (r_work.is_erase) begin
                                if (r_len != '0) begin
                                    n_len    = r_len - 1'b1;
                                    n_nerase = LINE_AW'(w_echo_on);
                                end
                            end else if (r_work.is_kill) begin
                                n_nerase = w_echo_on ? r_len : '0;
                                n_len    = '0;
                            end else if (r_work.is_nl) begin
                                n_echo[0] = CH_NL;
                                n_necho   = w_echo_on ? 2'd1 : 2'd0;
                                n_state   = S_CPRD;
                            end else if (r_len != LINE_AW'(LINE_SIZE - 1)) begin
                                w_lwe     = 1'b1;
                                n_len     = r_len + 1'b1;
                                n_echo[0] = r_work.ch;
                                n_necho   = w_echo_on ? 2'd1 : 2'd0;
                            end
                        end else begin
                            // raw push
                            if (r_cnt != CNT_W'(RING_SIZE)) begin
                                w_rwe  = 1'b1;
                                n_tail = (r_tail == RING_AW'(RING_SIZE - 1)) ? '0
                                         : r_tail + 1'b1;
                                n_cnt  = r_cnt + 1'b1;
                            end
                            n_echo[0] = r_work.ch;
                            n_necho   = w_echo_on ? 2'd1 : 2'd0;
                        end
                    end
                    CMD_READ: begin
                        priority if (!can_read(r_eof_f, r_rdy_f, w_canon, r_cnt)) begin
                            n_fkind = K_NONE;
                        end else if (r_cnt == '0) begin
                            if (r_eof_f) n_eof_f = 1'b0;
                            n_rdy_f = 1'b0;
                            n_fkind = K_EOF;
                        end else begin
                            n_state = S_RDWT;
                        end
                    end
                    CMD_FLUSH: begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_cnt   = '0;
                        n_len   = '0;
                        n_rdy_f = 1'b0;
                    end
                    default: ;
                endcase
            end
            S_CPRD: begin
                n_state = (r_idx == r_len) ? S_CPNL : S_CPWR;
            end
            S_CPWR, S_CPNL: begin
                w_rdata = (r_state == S_CPNL) ? CH_NL : r_line_q;
                if (r_cnt != CNT_W'(RING_SIZE)) begin
                    w_rwe  = 1'b1;
                    n_tail = (r_tail == RING_AW'(RING_SIZE - 1)) ? '0 : r_tail + 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_state == S_CPNL) begin
                    n_len   = '0;
                    n_rdy_f = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CPRD;
                end
            end
            S_RDWT: begin
                n_fkind  = K_READ;
                n_fvalue = r_ring_q;
                n_head   = (r_head == RING_AW'(RING_SIZE - 1)) ? '0 : r_head + 1'b1;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) n_rdy_f = 1'b0;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_oread  = can_read(r_eof_f, r_rdy_f, w_canon, r_cnt);
                    n_olast  = 1'b0;
                    priority if (r_eidx != r_necho) begin
                        n_okind  = K_ECHO;
                        n_ovalue = r_echo[r_eidx];
                        n_eidx   = r_eidx + 1'b1;
                    end else if (r_nerase != '0) begin
                        n_okind  = K_ERASE;
                        n_ovalue = 8'd0;
                        n_nerase = r_nerase - 1'b1;
                    end else begin
                        n_okind  = r_fkind;
                        n_ovalue = r_fvalue;
                        n_olast  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_rdy_f  <= 1'b0;
            r_eof_f  <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
            r_rdy_f  <= n_rdy_f;
            r_eof_f  <= n_eof_f;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
        end
        if (r_state == S_IDLE && i_work_valid) r_work <= i_work;
        r_nerase <= n_nerase;
        r_echo   <= n_echo;
        r_necho  <= n_necho;
        r_eidx   <= n_eidx;
        r_fkind  <= n_fkind;
        r_fvalue <= n_fvalue;
        r_okind  <= n_okind;
        r_ovalue <= n_ovalue;
        r_olast  <= n_olast;
        r_oread  <= n_oread;
    end

    assign o_res.valid    = r_ovalid;
    assign o_res.kind     = r_okind;
    assign o_res.value    = r_ovalue;
    assign o_res.last     = r_olast;
    assign o_res.readable = r_oread;
endmodule
`default_nettype wire

/* hdl/tld_check.sv */
// ----------------------------------------------------------------------------
// tld_check: port-level checks for the line discipline
// Watches the result channel for framing and value rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tld_check (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       i_ready,
    input wire [2:0] i_kind,
    input wire [7:0] i_value,
    input wire       i_last
);
    import tld_pkg::*;

    // hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_value))
        else $error("result word changed while stalled");

    // read outcomes and done always close a command
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == K_DONE || i_kind == K_READ || i_kind == K_EOF ||
                    i_kind == K_NONE) |-> i_last)
        else $error("final kind without last");

    // echo and erase never close a command
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == K_ECHO || i_kind == K_ERASE) |-> !i_last)
        else $error("echo word flagged last");

    // zero value for kinds without data
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != K_ECHO && i_kind != K_READ |-> i_value == 8'd0)
        else $error("nonzero value on data-less kind");
endmodule

bind terminal_line_discipline tld_check u_tld_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_kind  (o_res.kind),
    .i_value (o_res.value),
    .i_last  (o_res.last)
);
`default_nettype wire
